FILE: rtl/pwm_pkg.sv
// shared types and constants for the pulse width measurement block
// no dependencies; used by every module under rtl
`timescale 1ns / 1ps

package pwm_pkg;

  localparam int COUNT_WIDTH   = 24;
  localparam int LOOP_CYCLES   = 16;
  localparam int CYCLES_PER_US = 16;  // must stay a power of two
  localparam int US_WIDTH      = 16;

  localparam logic [US_WIDTH-1:0] US_MAX = {US_WIDTH{1'b1}};

  localparam logic [COUNT_WIDTH-1:0] TIMEOUT_RESET = COUNT_WIDTH'(100000);

  // request kinds
  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // result status codes
  localparam logic STATUS_MEASURED = 1'b0;
  localparam logic STATUS_TIMEOUT  = 1'b1;

  // configuration register indexes
  localparam logic REG_ACTIVE_LEVEL  = 1'b0;
  localparam logic REG_TIMEOUT_LOOPS = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_WAIT_END   = 2'd1,
    PH_WAIT_START = 2'd2,
    PH_COUNT      = 2'd3
  } phase_t;

  typedef struct packed {
    logic                   status;
    logic [COUNT_WIDTH-1:0] width_loops;
    logic [US_WIDTH-1:0]    width_us;
  } result_t;

endpackage

FILE: rtl/pwm_core.sv
// measurement state machine: phase, loop budget and pulse counter
// updated once per accepted request; depends on pwm_pkg
`timescale 1ns / 1ps

module pwm_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic                            kind,
  input  logic                            level,
  input  logic                            active_level,
  input  logic [pwm_pkg::COUNT_WIDTH-1:0] timeout_loops,
  output logic                            emit,
  output pwm_pkg::result_t                result
);

  localparam int US_PROD_W = pwm_pkg::COUNT_WIDTH + 8;

  pwm_pkg::phase_t                 phase, phase_next;
  logic [pwm_pkg::COUNT_WIDTH-1:0] budget_left, budget_next;
  logic [pwm_pkg::COUNT_WIDTH-1:0] pulse_count, count_next;

  logic                            act;
  logic                            spent_out;
  logic [pwm_pkg::COUNT_WIDTH-1:0] budget_spent;
  logic [pwm_pkg::COUNT_WIDTH-1:0] count_inc;
  logic [US_PROD_W-1:0]            us_full;
  logic [pwm_pkg::US_WIDTH-1:0]    us_sat;

  assign act = (level == active_level);

  // one waiting pass spends a unit of budget, never wrapping below zero
  assign spent_out    = (budget_left <= pwm_pkg::COUNT_WIDTH'(1));
  assign budget_spent = spent_out ? '0 : budget_left - pwm_pkg::COUNT_WIDTH'(1);
  assign count_inc    = pulse_count + pwm_pkg::COUNT_WIDTH'(1);

  assign us_full = ((US_PROD_W'(pulse_count) + US_PROD_W'(1))
                    * US_PROD_W'(pwm_pkg::LOOP_CYCLES))
                   / US_PROD_W'(pwm_pkg::CYCLES_PER_US);
  assign us_sat  = (us_full > US_PROD_W'(pwm_pkg::US_MAX)) ? pwm_pkg::US_MAX
                                                           : us_full[pwm_pkg::US_WIDTH-1:0];

  always_comb begin
    phase_next         = phase;
    budget_next        = budget_left;
    count_next         = pulse_count;
    emit               = 1'b0;
    result.status      = pwm_pkg::STATUS_TIMEOUT;
    result.width_loops = '0;
    result.width_us    = '0;
    if (kind == pwm_pkg::KIND_START) begin
      phase_next  = pwm_pkg::PH_WAIT_END;
      budget_next = timeout_loops;
      count_next  = '0;
    end else begin
      case (phase)
        pwm_pkg::PH_WAIT_END: begin
          // an inactive sample also counts as the first pass of wait_start
          budget_next = budget_spent;
          if (spent_out) begin
            emit       = 1'b1;
            phase_next = pwm_pkg::PH_IDLE;
          end else if (!act) begin
            phase_next = pwm_pkg::PH_WAIT_START;
          end
        end
        pwm_pkg::PH_WAIT_START: begin
          if (!act) begin
            budget_next = budget_spent;
            if (spent_out) begin
              emit       = 1'b1;
              phase_next = pwm_pkg::PH_IDLE;
            end
          end else begin
            // pulse begins: this sample is the first counted one
            count_next = pwm_pkg::COUNT_WIDTH'(1);
            if (budget_left == pwm_pkg::COUNT_WIDTH'(1)) begin
              emit       = 1'b1;
              phase_next = pwm_pkg::PH_IDLE;
            end else begin
              phase_next = pwm_pkg::PH_COUNT;
            end
          end
        end
        pwm_pkg::PH_COUNT: begin
          if (act) begin
            count_next = count_inc;
            if (count_inc == budget_left) begin
              emit       = 1'b1;
              phase_next = pwm_pkg::PH_IDLE;
            end
          end else begin
            emit               = 1'b1;
            phase_next         = pwm_pkg::PH_IDLE;
            result.status      = pwm_pkg::STATUS_MEASURED;
            result.width_loops = pulse_count;
            result.width_us    = us_sat;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= pwm_pkg::PH_IDLE;
      budget_left <= '0;
      pulse_count <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      budget_left <= budget_next;
      pulse_count <= count_next;
    end
  end

endmodule

FILE: rtl/pwm_out_buf.sv
// result register with a skid stage so requests keep flowing under backpressure
// depends on pwm_pkg for the result type
`timescale 1ns / 1ps

module pwm_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pwm_pkg::result_t push_data,
  output logic             can_push,
  output logic             out_valid,
  input  logic             out_ready,
  output pwm_pkg::result_t out_data
);

  logic             skid_valid;
  pwm_pkg::result_t skid_data;
  logic             out_free;

  assign can_push = !skid_valid;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (out_free) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        out_data <= skid_data;
      end
    end else if (out_free) begin
      if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

FILE: rtl/pulse_width_measure_unit.sv
// Pulse width measurement: a start request loads the loop budget, then each
// sample request is one loop pass (wait out a pulse in progress, wait for the
// pulse to begin, count active samples). One request is taken every clock
// unless input stalls; the state update is registered, and the result of
// the ending sample is registered into the output buffer. A two-deep result
// buffer lets input keep flowing while a result waits; input stalls only
// when both entries are full. Configuration writes are taken every cycle.
// depends on pwm_pkg, pwm_core, pwm_out_buf
`timescale 1ns / 1ps

module pulse_width_measure_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            kind,
  input  logic                            level,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            status,
  output logic [pwm_pkg::COUNT_WIDTH-1:0] width_loops,
  output logic [pwm_pkg::US_WIDTH-1:0]    width_us,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [pwm_pkg::COUNT_WIDTH-1:0] cfg_data
);

  logic                            active_level;
  logic [pwm_pkg::COUNT_WIDTH-1:0] timeout_loops;
  logic                            accept;
  logic                            emit;
  pwm_pkg::result_t                core_result;
  pwm_pkg::result_t                out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_level  <= 1'b1;
      timeout_loops <= pwm_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        pwm_pkg::REG_ACTIVE_LEVEL:  active_level  <= cfg_data[0];
        pwm_pkg::REG_TIMEOUT_LOOPS: timeout_loops <= cfg_data;
        default: begin
          active_level <= active_level;
        end
      endcase
    end
  end

  assign accept = in_valid && in_ready;

  pwm_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .kind          (kind),
    .level         (level),
    .active_level  (active_level),
    .timeout_loops (timeout_loops),
    .emit          (emit),
    .result        (core_result)
  );

  pwm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && emit),
    .push_data (core_result),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign status      = out_data.status;
  assign width_loops = out_data.width_loops;
  assign width_us    = out_data.width_us;

endmodule
